@@ rtl/multiversion_snapshot_store_macros.svh @@
// Assertion helpers for the multiversion snapshot store.
// Each helper expects clk and arst_n in scope.
`ifndef MULTIVERSION_SNAPSHOT_STORE_MACROS_SVH
`define MULTIVERSION_SNAPSHOT_STORE_MACROS_SVH

// Plain property, sampled on the rising clock edge and off during reset.
`define MSS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Next-cycle implication.
`define MSS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/mss_pkg.sv @@
// ----------------------------------------------------------------------------
// mss_pkg
// Shared types and codes for the multiversion snapshot store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mss_pkg;

	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_SNAP   = 2'd1;
	localparam logic [1:0] CMD_LATEST = 2'd2;

	localparam logic [1:0] STAT_OK     = 2'd0;
	localparam logic [1:0] STAT_NONE   = 2'd1;
	localparam logic [1:0] STAT_REJECT = 2'd2;
	localparam logic [1:0] STAT_OVWR   = 2'd3;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [1:0]  replica_slot;
		logic [63:0] update_time;
		logic [31:0] value_ref;
		logic [63:0] snapshot_time;
	} mss_in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] found_value;
		logic [63:0] found_time;
		logic [1:0]  found_replica;
	} mss_out_t;

	// Control from the sequencer to one replica lane.
	typedef struct packed {
		logic clr;
		logic scan;
		logic wr;
	} mss_lane_ctl_t;

	// Status from one replica lane to the sequencer.
	typedef struct packed {
		logic        empty;
		logic        full;
		logic        hit;
		logic [63:0] head_time;
		logic [63:0] hit_time;
		logic [31:0] hit_value;
	} mss_lane_stat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS,
		ST_SCAN,
		ST_DRAIN,
		ST_MERGE,
		ST_OUT
	} mss_state_t;

endpackage

@@ rtl/mss_ram.sv @@
// ----------------------------------------------------------------------------
// mss_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ rtl/mss_lane.sv @@
// ----------------------------------------------------------------------------
// mss_lane
// One replica's version stack: entry memory, head pointer, fill count and the
// first-visible tracker used during a snapshot scan.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mss_lane #(
	parameter int STACK_DEPTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  mss_pkg::mss_lane_ctl_t         ctl,
	input  logic [$clog2(STACK_DEPTH)-1:0] k,
	input  logic [63:0]                    snap_time,
	input  logic [63:0]                    wr_time,
	input  logic [31:0]                    wr_value,
	output mss_pkg::mss_lane_stat_t        stat
);
	import mss_pkg::*;

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam logic [AW:0]   DEPTH_W = (AW + 1)'(STACK_DEPTH);
	localparam logic [AW-1:0] LAST    = AW'(STACK_DEPTH - 1);
	localparam logic [CW-1:0] FULL    = CW'(STACK_DEPTH);

	logic [AW-1:0] head_q;
	logic [CW-1:0] cnt_q;
	logic [AW-1:0] head_nxt;
	logic [AW:0]   age_sum;
	logic [AW-1:0] raddr;
	logic [95:0]   rdata;
	logic          scan_s1;
	logic [AW-1:0] k_s1;
	logic          hit_q;
	logic [63:0]   hit_time_q;
	logic [31:0]   hit_value_q;
	logic [63:0]   rd_time;

	assign head_nxt = (head_q == LAST) ? '0 : head_q + 1'b1;

	// Entry k steps older than the head, wrapping around the ring.
	assign age_sum = ({1'b0, head_q} >= {1'b0, k}) ? ({1'b0, head_q} - {1'b0, k})
		: ({1'b0, head_q} + DEPTH_W - {1'b0, k});
	assign raddr   = ctl.scan ? age_sum[AW-1:0] : head_q;

	mss_ram #(.WIDTH(96), .DEPTH(STACK_DEPTH)) u_ram (
		.clk   (clk),
		.we    (ctl.wr),
		.waddr (head_nxt),
		.wdata ({wr_time, wr_value}),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign rd_time = rdata[95:32];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			cnt_q   <= '0;
			scan_s1 <= 1'b0;
			hit_q   <= 1'b0;
		end else begin
			scan_s1 <= ctl.scan;
			if (ctl.wr) begin
				head_q <= head_nxt;
				if (cnt_q != FULL) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			if (ctl.clr) begin
				hit_q <= 1'b0;
			end else if (scan_s1 && !hit_q && (CW'(k_s1) < cnt_q) && (rd_time <= snap_time)) begin
				hit_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		k_s1 <= k;
		if (scan_s1 && !hit_q && !ctl.clr) begin
			hit_time_q  <= rd_time;
			hit_value_q <= rdata[31:0];
		end
	end

	always_comb begin
		stat.empty     = (cnt_q == '0);
		stat.full      = (cnt_q == FULL);
		stat.hit       = hit_q;
		stat.head_time = rd_time;
		stat.hit_time  = hit_time_q;
		stat.hit_value = hit_value_q;
	end
endmodule

@@ rtl/multiversion_snapshot_store.sv @@
// ----------------------------------------------------------------------------
// multiversion_snapshot_store
// Per-key version store with one newest-first stack per source replica,
// snapshot reads over all replicas and a tracked latest version.
// ----------------------------------------------------------------------------
//
//  Channel | Signals                        | Payload
//  --------+--------------------------------+-----------------------------
//  input   | in_valid, in_ready, in_item    | cmd, slot, times, value ref
//  output  | out_valid, out_ready, out_item | status, found version fields
//
// Steps: an insert goes through head read, compare and write, then result;
// a latest read is complete at once; a snapshot read scans one stack
// position per cycle in all replica memories at once, then the per-replica
// hits are merged one replica per cycle.
// Reset: arst_n clears stack heads, counts, latest tracking and control; the
// entry memories need no clearing since only written entries are read.
// Stalls: a finished result waits in the output register while the next
// item is taken; a second result waits until that register frees.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "multiversion_snapshot_store_macros.svh"

module multiversion_snapshot_store #(
	parameter int REPLICAS    = 4,
	parameter int STACK_DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  mss_pkg::mss_in_t  in_item,
	output logic              out_valid,
	input  logic              out_ready,
	output mss_pkg::mss_out_t out_item
);
	import mss_pkg::*;

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int LW = (REPLICAS > 1) ? $clog2(REPLICAS) : 1;
	localparam logic [AW-1:0] K_LAST = AW'(STACK_DEPTH - 1);
	localparam logic [LW-1:0] R_LAST = LW'(REPLICAS - 1);

	mss_state_t     state_q, state_nxt;
	mss_in_t        req_q;
	mss_out_t       res_q;
	mss_out_t       res_init;
	logic           out_valid_q;
	mss_out_t       out_item_q;
	logic [AW-1:0]  k_q;
	logic [LW-1:0]  r_q;
	logic           have_q;
	logic [63:0]    best_time_q;
	logic [31:0]    best_value_q;
	logic [LW-1:0]  best_rep_q;
	logic           lat_valid_q;
	logic [63:0]    lat_time_q;
	logic [31:0]    lat_value_q;
	logic [1:0]     lat_rep_q;

	mss_lane_ctl_t  lane_ctl  [REPLICAS];
	mss_lane_stat_t lane_stat [REPLICAS];
	logic [REPLICAS-1:0] lane_wr;

	logic           in_fire;
	logic           out_load;
	logic           slot_ok;
	logic [LW-1:0]  slot_idx;
	mss_lane_stat_t sel_stat;
	mss_lane_stat_t mrg_stat;
	logic           ins_reject;
	logic           mrg_take;
	logic           scan_en;
	logic           clr_en;

	// Lanes: one memory and one hit tracker per replica.
	for (genvar g = 0; g < REPLICAS; g++) begin : g_lane
		assign lane_ctl[g].clr  = clr_en;
		assign lane_ctl[g].scan = scan_en;
		assign lane_ctl[g].wr   = lane_wr[g];

		mss_lane #(.STACK_DEPTH(STACK_DEPTH)) u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (lane_ctl[g]),
			.k         (k_q),
			.snap_time (req_q.snapshot_time),
			.wr_time   (req_q.update_time),
			.wr_value  (req_q.value_ref),
			.stat      (lane_stat[g])
		);
	end

	assign in_fire  = in_valid && in_ready;
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_ready);
	assign slot_ok  = (int'(req_q.replica_slot) < REPLICAS);
	assign slot_idx = LW'(req_q.replica_slot);
	assign sel_stat = lane_stat[slot_idx];
	assign mrg_stat = lane_stat[r_q];

	// Inserts older than a nonempty stack's head are refused.
	assign ins_reject = !sel_stat.empty && (req_q.update_time < sel_stat.head_time);
	// Strictly newer wins, so the lowest replica keeps ties.
	assign mrg_take   = mrg_stat.hit && (!have_q || (mrg_stat.hit_time > best_time_q));

	// Starting result of a new item: inserts begin as rejected until the head
	// compare passes, latest reads are complete at once.
	always_comb begin
		res_init = '0;
		if (in_item.cmd == CMD_INSERT) begin
			res_init.status = STAT_REJECT;
		end else if (in_item.cmd == CMD_LATEST) begin
			if (lat_valid_q) begin
				res_init.status        = STAT_OK;
				res_init.found_value   = lat_value_q;
				res_init.found_time    = lat_time_q;
				res_init.found_replica = lat_rep_q;
			end else begin
				res_init.status = STAT_NONE;
			end
		end else begin
			res_init.status = STAT_OK;
		end
	end

	// Next state.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (in_item.cmd == CMD_INSERT
						&& int'(in_item.replica_slot) < REPLICAS) begin
						state_nxt = ST_INS;
					end else if (in_item.cmd == CMD_SNAP) begin
						state_nxt = ST_SCAN;
					end else begin
						state_nxt = ST_OUT;
					end
				end
			end
			ST_INS:   state_nxt = ST_OUT;
			ST_SCAN:  state_nxt = (k_q == K_LAST) ? ST_DRAIN : ST_SCAN;
			ST_DRAIN: state_nxt = ST_MERGE;
			ST_MERGE: state_nxt = (r_q == R_LAST) ? ST_OUT : ST_MERGE;
			ST_OUT:   state_nxt = out_load ? ST_IDLE : ST_OUT;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	// Control outputs.
	always_comb begin
		in_ready = 1'b0;
		scan_en  = 1'b0;
		clr_en   = 1'b0;
		lane_wr  = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				clr_en   = in_valid && (in_item.cmd == CMD_SNAP);
			end
			ST_INS: begin
				if (slot_ok && !ins_reject) begin
					lane_wr[slot_idx] = 1'b1;
				end
			end
			ST_SCAN:  scan_en = 1'b1;
			ST_DRAIN, ST_MERGE, ST_OUT: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			lat_valid_q <= 1'b0;
			lat_time_q  <= '0;
			lat_value_q <= '0;
			lat_rep_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			// An accepted insert becomes the latest version when its stack was
			// empty, when nothing is tracked yet, or when it is strictly newer.
			if (state_q == ST_INS && slot_ok && !ins_reject
				&& (sel_stat.empty || !lat_valid_q || lat_time_q < req_q.update_time)) begin
				lat_valid_q <= 1'b1;
				lat_time_q  <= req_q.update_time;
				lat_value_q <= req_q.value_ref;
				lat_rep_q   <= req_q.replica_slot;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_item_q <= res_q;
		end
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					req_q  <= in_item;
					k_q    <= '0;
					r_q    <= '0;
					have_q <= 1'b0;
					res_q  <= res_init;
				end
			end
			ST_INS: begin
				if (!ins_reject) begin
					res_q.status <= sel_stat.full ? STAT_OVWR : STAT_OK;
				end
			end
			ST_SCAN: begin
				k_q <= k_q + 1'b1;
			end
			ST_MERGE: begin
				r_q <= r_q + 1'b1;
				if (mrg_take) begin
					have_q       <= 1'b1;
					best_time_q  <= mrg_stat.hit_time;
					best_value_q <= mrg_stat.hit_value;
					best_rep_q   <= r_q;
				end
				if (r_q == R_LAST) begin
					if (mrg_take) begin
						res_q <= '{status: STAT_OK, found_value: mrg_stat.hit_value,
							found_time: mrg_stat.hit_time, found_replica: 2'(r_q)};
					end else if (have_q) begin
						res_q <= '{status: STAT_OK, found_value: best_value_q,
							found_time: best_time_q, found_replica: 2'(best_rep_q)};
					end else begin
						res_q <= '{status: STAT_NONE, default: '0};
					end
				end
			end
			ST_DRAIN, ST_OUT: begin
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	`MSS_ASSERT(a_one_lane_write, $onehot0(lane_wr), "more than one replica lane written")
	`MSS_ASSERT_NEXT(a_latest_after_insert, (state_q == ST_INS) && (lane_wr != '0),
		lat_valid_q, "latest version not tracked after an insert")
	`MSS_ASSERT(a_out_from_result, $rose(out_valid_q) |-> $past(state_q == ST_OUT),
		"result presented without a finished item")
	`MSS_ASSERT(a_no_accept_busy, in_fire |-> (state_q == ST_IDLE) && !scan_en,
		"item taken while the store is busy")
endmodule

@@ verif/tb_multiversion_snapshot_store.sv @@
// ----------------------------------------------------------------------------
// tb_multiversion_snapshot_store
// Drives inserts, snapshot reads and latest reads into the version store,
// predicts every result from a behavioral copy of the stacks, and checks
// each output transfer field by field, with random idling on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_multiversion_snapshot_store;
	import mss_pkg::*;

	typedef bit bool_t;

	localparam int NREP  = 4;
	localparam int DEPTH = 16;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam longint CYCLE_LIMIT = 400000;

	logic     clk;
	logic     arst_n;
	logic     in_valid;
	logic     in_ready;
	mss_in_t  in_item;
	logic     out_valid;
	logic     out_ready;
	mss_out_t out_item;

	multiversion_snapshot_store #(.REPLICAS(NREP), .STACK_DEPTH(DEPTH)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// Behavioral copy of the store: one newest-first ring per replica.
	logic [63:0] ver_time [NREP][DEPTH];
	logic [31:0] ver_value[NREP][DEPTH];
	int          ring_head[NREP];
	int          ring_fill[NREP];
	logic [63:0] last_time;
	logic [31:0] last_value;
	logic [1:0]  last_replica;
	logic        last_valid;

	mss_in_t  pending_items[$];
	mss_out_t expected_results[$];
	int       mismatches;
	int       results_seen;
	int       inserts_sent, snaps_sent, latests_sent;
	longint   cycle_count;
	bool_t    hold_off_active;
	int       hold_off_left;
	bit       calm_stretch;
	bit       in_ready_seen;

	function automatic mss_out_t apply_item(mss_in_t it);
		mss_out_t r;
		int s, h, n, k, p;
		bit have;
		r = '0;
		case (it.cmd)
			CMD_INSERT: begin
				s = it.replica_slot;
				if (s >= NREP) begin
					r.status = STAT_REJECT;
					return r;
				end
				h = ring_head[s];
				n = ring_fill[s];
				if (n > 0 && it.update_time < ver_time[s][h]) begin
					r.status = STAT_REJECT;
					return r;
				end
				h = (h + 1 >= DEPTH) ? 0 : h + 1;
				ver_time[s][h] = it.update_time;
				ver_value[s][h] = it.value_ref;
				ring_head[s] = h;
				if (n == DEPTH) r.status = STAT_OVWR;
				else begin
					r.status = STAT_OK;
					ring_fill[s] = n + 1;
				end
				if (n == 0 || !last_valid || last_time < it.update_time) begin
					last_time = it.update_time;
					last_value = it.value_ref;
					last_replica = s[1:0];
					last_valid = 1'b1;
				end
			end
			CMD_SNAP: begin
				have = 1'b0;
				for (s = 0; s < NREP; s++) begin
					for (k = 0; k < ring_fill[s]; k++) begin
						p = (ring_head[s] >= k) ? ring_head[s] - k : ring_head[s] + DEPTH - k;
						if (ver_time[s][p] <= it.snapshot_time) begin
							if (!have || ver_time[s][p] > r.found_time) begin
								have = 1'b1;
								r.found_time = ver_time[s][p];
								r.found_value = ver_value[s][p];
								r.found_replica = s[1:0];
							end
							break;
						end
					end
				end
				r.status = have ? STAT_OK : STAT_NONE;
			end
			CMD_LATEST: begin
				if (last_valid) begin
					r.status = STAT_OK;
					r.found_value = last_value;
					r.found_time = last_time;
					r.found_replica = last_replica;
				end else r.status = STAT_NONE;
			end
			default: r = '0;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch at result %0d: %s got %h expected %h", results_seen, what, got, want);
		mismatches++;
	endtask

	task automatic add_item(input mss_in_t it);
		pending_items.insert(pending_items.size(), it);
	endtask

	// Driver: presents queued items, predicting each one on its transfer.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
		end else if (in_valid && in_ready) begin
			expected_results.insert(expected_results.size(), apply_item(in_item));
			case (in_item.cmd)
				CMD_INSERT: inserts_sent++;
				CMD_SNAP: snaps_sent++;
				CMD_LATEST: latests_sent++;
				default: ;
			endcase
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_ready_seen) begin
			if (pending_items.size() > 0 && (calm_stretch || $urandom_range(99) >= 31)) begin
				in_item <= pending_items.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// The transfer is decided at the rising edge; remember it for the falling edge.
	always @(posedge clk) in_ready_seen <= in_valid && in_ready;

	// Receiver: random stalls, plus one long hold-off that lets the block fill up.
	always @(negedge clk) begin
		if (!arst_n) out_ready <= 1'b0;
		else if (hold_off_active) begin
			out_ready <= 1'b0;
			if (hold_off_left == 0) hold_off_active <= 1'b0;
			else hold_off_left <= hold_off_left - 1;
		end else out_ready <= calm_stretch || ($urandom_range(99) >= 31);
	end

	// Monitor: compares each output transfer with the oldest prediction.
	always @(posedge clk) begin
		mss_out_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				report_mismatch("result with no prediction pending", '0, '0);
			end else begin
				want = expected_results.pop_front();
				if (out_item.status !== want.status)
					report_mismatch("status", 64'(out_item.status), 64'(want.status));
				if (out_item.found_value !== want.found_value)
					report_mismatch("found_value", 64'(out_item.found_value),
						64'(want.found_value));
				if (out_item.found_time !== want.found_time)
					report_mismatch("found_time", out_item.found_time, want.found_time);
				if (out_item.found_replica !== want.found_replica)
					report_mismatch("found_replica", 64'(out_item.found_replica),
						64'(want.found_replica));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("** multiversion_snapshot_store: FAILED **");
			$finish;
		end
	end

	function automatic mss_in_t make_item(logic [1:0] c, logic [1:0] s, logic [63:0] ut,
			logic [31:0] v, logic [63:0] st);
		mss_in_t it;
		it.cmd = c;
		it.replica_slot = s;
		it.update_time = ut;
		it.value_ref = v;
		it.snapshot_time = st;
		return it;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	initial begin
		logic [63:0] clock_base[NREP];
		logic [63:0] t;
		int i, s, phase;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		out_ready = 1'b0;
		mismatches = 0;
		results_seen = 0;
		inserts_sent = 0;
		snaps_sent = 0;
		latests_sent = 0;
		cycle_count = 0;
		hold_off_active = 1'b0;
		hold_off_left = 0;
		calm_stretch = 1'b0;
		in_ready_seen = 1'b0;
		last_time = '0;
		last_value = '0;
		last_replica = '0;
		last_valid = 1'b0;
		for (s = 0; s < NREP; s++) begin
			ring_head[s] = 0;
			ring_fill[s] = 0;
		end

		// Directed part: reads on an empty store, extreme fields, equal-time and
		// older inserts, the ignored command, and a tie across replicas.
		add_item(make_item(CMD_LATEST, 2'd0, '0, '0, '0));
		add_item(make_item(CMD_SNAP, 2'd0, '0, '0, '1));
		add_item(make_item(CMD_UNUSED, 2'd3, '1, '1, '1));
		add_item(make_item(CMD_INSERT, 2'd0, 64'd100, 32'hFFFF_FFFF, '0));
		add_item(make_item(CMD_INSERT, 2'd0, 64'd100, 32'h1, '0));
		add_item(make_item(CMD_INSERT, 2'd0, 64'd99, 32'h2, '0));
		add_item(make_item(CMD_INSERT, 2'd2, 64'd100, 32'h3, '0));
		add_item(make_item(CMD_INSERT, 2'd3, '0, '0, '0));
		add_item(make_item(CMD_SNAP, 2'd1, '0, '0, 64'd100));
		add_item(make_item(CMD_SNAP, 2'd1, '0, '0, 64'd99));
		add_item(make_item(CMD_SNAP, 2'd1, '0, '0, '0));
		add_item(make_item(CMD_LATEST, 2'd3, '1, '1, '1));
		add_item(make_item(CMD_INSERT, 2'd1, '1, 32'hA5A5_5A5A, '1));
		add_item(make_item(CMD_SNAP, 2'd0, '0, '0, '1));
		add_item(make_item(CMD_LATEST, 2'd0, '0, '0, '0));
		// Overfill replica 3 so the oldest entry is overwritten.
		for (i = 0; i < DEPTH + 2; i++)
			add_item(make_item(CMD_INSERT, 2'd3, 64'd10 + i, 32'(i), '0));
		add_item(make_item(CMD_SNAP, 2'd0, '0, '0, 64'd10));
		add_item(make_item(CMD_SNAP, 2'd0, '0, '0, 64'd12));

		// Random part: mostly ascending timestamps per replica so inserts land and
		// snapshots find history; some out-of-order and wide-range noise.
		for (s = 0; s < NREP; s++) clock_base[s] = 64'd200;
		for (i = 0; i < 600; i++) begin
			phase = $urandom_range(99);
			s = $urandom_range(NREP - 1);
			if (phase < 50) begin
				if ($urandom_range(9) == 0) t = rand64();
				else if ($urandom_range(9) == 0) t = clock_base[s] - $urandom_range(20);
				else begin
					clock_base[s] = clock_base[s] + $urandom_range(8);
					t = clock_base[s];
				end
				add_item(make_item(CMD_INSERT, s[1:0], t, $urandom(), rand64()));
			end else if (phase < 85) begin
				t = ($urandom_range(9) == 0) ? rand64() : 64'd180 + $urandom_range(400);
				add_item(make_item(CMD_SNAP, 2'($urandom()), rand64(), $urandom(), t));
			end else if (phase < 97) begin
				add_item(make_item(CMD_LATEST, 2'($urandom()), rand64(), $urandom(),
					rand64()));
			end else begin
				add_item(make_item(CMD_UNUSED, 2'($urandom()), rand64(), $urandom(),
					rand64()));
			end
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Long receiver hold-off early on while the sender keeps offering items.
		repeat (40) @(posedge clk);
		hold_off_left = 300;
		hold_off_active = 1'b1;
		wait (!hold_off_active);
		// A stretch with no idling on either side.
		repeat (200) @(posedge clk);
		calm_stretch = 1'b1;
		repeat (1500) @(posedge clk);
		calm_stretch = 1'b0;

		wait (pending_items.size() == 0 && !in_valid);
		wait (expected_results.size() == 0);
		repeat (DEPTH + NREP + 20) @(posedge clk);

		$display("covered %0d inserts, %0d snapshot reads, %0d latest reads; %0d results checked",
			inserts_sent, snaps_sent, latests_sent, results_seen);
		if (mismatches == 0) begin
			$display("** multiversion_snapshot_store: PASSED **");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("** multiversion_snapshot_store: FAILED **");
		end
		$finish;
	end

endmodule
